>>> design/rme_pkg.sv
package rme_pkg;

	localparam int NUM_REGS_DEF = 6;
	localparam int MAX_PROGRAM = 256;
	localparam int DATA_W = 64;
	localparam int OPND_W = 32;
	localparam int IP_W = 3;
	localparam int PLEN_W = 9;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_IP_REGISTER = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_LENGTH = CFG_IDX_W'(1);

	typedef enum logic [3:0] {
		OP_ADDR = 4'd0,
		OP_ADDI = 4'd1,
		OP_MULR = 4'd2,
		OP_MULI = 4'd3,
		OP_BANR = 4'd4,
		OP_BANI = 4'd5,
		OP_BORR = 4'd6,
		OP_BORI = 4'd7,
		OP_SETR = 4'd8,
		OP_SETI = 4'd9,
		OP_GTIR = 4'd10,
		OP_GTRI = 4'd11,
		OP_GTRR = 4'd12,
		OP_EQIR = 4'd13,
		OP_EQRI = 4'd14,
		OP_EQRR = 4'd15
	} op_t;

	typedef struct packed {
		logic [3:0] opcode;
		logic [OPND_W-1:0] operand_a;
		logic [OPND_W-1:0] operand_b;
		logic [OPND_W-1:0] dest_index;
	} instr_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] written_value;
		logic [2:0] dest_reg;
		logic signed [DATA_W-1:0] next_pc;
		logic halted;
		logic fault;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] reg_index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_t;

	// Execute-stage outcome handed from the ALU to the top level
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] pc;
		logic halted;
		logic fault;
		logic is_mul;
	} exec_t;

endpackage

>>> design/rme_chan_if.sv
interface rme_chan_if #(
	parameter type payload_t = logic
) ();
	logic valid;
	logic ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> design/register_machine_execute.sv
// Register machine execute unit: runs one instruction of a six-register,
// sixteen-opcode machine per item.
//
// Channels: instr (sink) takes opcode, two operands and a destination index;
// result (source) gives the written value, destination, next pc, halted and
// fault; cfg (sink) writes ip_register (index 0) and program_length (index 1).
//
// Path: an accepted item sits in the execute register and then lands in the
// result register, from which its result is offered; mulr/muli wait in the
// execute register until their 64-bit product, formed from registered 32x32
// partial products, is ready. Throughput: one item per cycle while results
// are taken and no multiply is waiting for its product.
// Register file: a 2-read/1-write RAM plus a separate pc register that shadows
// the bound register; results feed the next item through a write bypass.
//
// Reset clears all registers to zero at once through per-entry valid bits;
// no clearing pass. A write to ip_register saves the pc; RL_READ and RL_LOAD
// reload it from a valid newly bound register, with instr and cfg not ready.
// When the receiver stalls, the result register holds, one more item waits
// in the execute register, and instr drops ready until the result is taken.
module register_machine_execute import rme_pkg::*; #(
	parameter int NUM_REGS = NUM_REGS_DEF
) (
	input logic clk,
	input logic arst_n,
	rme_chan_if.sink instr,
	rme_chan_if.source result,
	rme_chan_if.sink cfg
);
	localparam int RIDX_W = $clog2(NUM_REGS);
	localparam logic [OPND_W-1:0] NREGS = OPND_W'(NUM_REGS);

	typedef enum logic [2:0] {
		RL_IDLE = 3'b001,
		RL_READ = 3'b010,
		RL_LOAD = 3'b100
	} rl_state_t;

	rl_state_t rl_state_q;
	logic [IP_W-1:0] ip_q;
	logic [PLEN_W-1:0] len_q;
	logic [DATA_W-1:0] pc_q;
	logic [NUM_REGS-1:0] valid_q;
	logic rl_vld_q;

	instr_t s1;
	instr_t instr_s1;
	logic s1_valid_q;
	logic a_byp_s1;
	logic b_byp_s1;
	logic a_vld_s1;
	logic b_vld_s1;
	logic [DATA_W-1:0] byp_s1;
	logic mul_done_q;

	logic out_valid_q;
	result_t out_q;

	logic in_fire;
	logic cfg_fire;
	logic s1_fire;
	logic cfg_save;
	logic exec_we;
	logic ram_we;
	logic [RIDX_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [RIDX_W-1:0] ip_idx;
	logic [RIDX_W-1:0] in_a_idx;
	logic [RIDX_W-1:0] in_b_idx;
	logic [RIDX_W-1:0] rd_a_addr;
	logic rd_a_en;
	logic [DATA_W-1:0] rd_a;
	logic [DATA_W-1:0] rd_b;
	logic [DATA_W-1:0] ra;
	logic [DATA_W-1:0] rb;
	logic [DATA_W-1:0] va;
	logic [DATA_W-1:0] vb;
	logic [DATA_W-1:0] mul_prod;
	logic ip_ok;
	logic new_ip_ok;
	exec_t ex;

	assign s1 = instr_s1;
	assign ip_idx = RIDX_W'(ip_q);
	assign ip_ok = OPND_W'(ip_q) < NREGS;
	assign new_ip_ok = OPND_W'(cfg.payload.wdata[IP_W-1:0]) < NREGS;
	assign in_a_idx = instr.payload.operand_a[RIDX_W-1:0];
	assign in_b_idx = instr.payload.operand_b[RIDX_W-1:0];

	assign s1_fire = s1_valid_q && (!ex.is_mul || mul_done_q)
		&& (!out_valid_q || result.ready);
	assign instr.ready = (rl_state_q == RL_IDLE) && (!s1_valid_q || s1_fire);
	assign cfg.ready = rl_state_q == RL_IDLE;
	assign in_fire = instr.valid && instr.ready;
	assign cfg_fire = cfg.valid && cfg.ready;

	// Rebinding the pc: store the shadow pc back into the old bound register
	assign cfg_save = cfg_fire && (cfg.payload.reg_index == CFG_IP_REGISTER) && ip_ok;
	assign exec_we = s1_fire && !ex.fault;
	assign ram_we = exec_we || cfg_save;
	assign ram_waddr = exec_we ? s1.dest_index[RIDX_W-1:0] : ip_idx;
	assign ram_wdata = exec_we ? ex.value : pc_q;

	assign rd_a_en = in_fire || (rl_state_q == RL_READ);
	assign rd_a_addr = (rl_state_q == RL_READ) ? ip_idx : in_a_idx;

	rme_ram #(
		.WIDTH(DATA_W),
		.DEPTH(NUM_REGS)
	) u_regs (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re_a(rd_a_en),
		.raddr_a(rd_a_addr),
		.rdata_a(rd_a),
		.re_b(in_fire),
		.raddr_b(in_b_idx),
		.rdata_b(rd_b)
	);

	// Operand resolve: bound register from the shadow pc, then bypass, then RAM
	always_comb begin
		if (s1.operand_a == OPND_W'(ip_q)) begin
			ra = pc_q;
		end else if (a_byp_s1) begin
			ra = byp_s1;
		end else begin
			ra = a_vld_s1 ? rd_a : '0;
		end
		if (s1.operand_b == OPND_W'(ip_q)) begin
			rb = pc_q;
		end else if (b_byp_s1) begin
			rb = byp_s1;
		end else begin
			rb = b_vld_s1 ? rd_b : '0;
		end
	end

	rme_alu #(
		.NUM_REGS(NUM_REGS)
	) u_alu (
		.opcode(s1.opcode),
		.operand_a(s1.operand_a),
		.operand_b(s1.operand_b),
		.dest_index(s1.dest_index),
		.ip_reg(ip_q),
		.prog_len(len_q),
		.pc(pc_q),
		.ra(ra),
		.rb(rb),
		.mul_prod(mul_prod),
		.va(va),
		.vb(vb),
		.ex(ex)
	);

	rme_mul u_mul (
		.clk(clk),
		.x(va),
		.y(vb),
		.prod(mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rl_state_q <= RL_IDLE;
			ip_q <= '0;
			len_q <= '0;
			pc_q <= '0;
			valid_q <= '0;
			rl_vld_q <= 1'b0;
			s1_valid_q <= 1'b0;
			mul_done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end

			case (rl_state_q)
				RL_IDLE: begin
					if (cfg_fire && (cfg.payload.reg_index == CFG_IP_REGISTER)) begin
						ip_q <= cfg.payload.wdata[IP_W-1:0];
						if (new_ip_ok) begin
							rl_state_q <= RL_READ;
						end
					end
					if (cfg_fire && (cfg.payload.reg_index == CFG_PROGRAM_LENGTH)) begin
						len_q <= cfg.payload.wdata[PLEN_W-1:0];
					end
				end
				RL_READ: begin
					rl_vld_q <= valid_q[ip_idx];
					rl_state_q <= RL_LOAD;
				end
				RL_LOAD: begin
					pc_q <= rl_vld_q ? rd_a : '0;
					rl_state_q <= RL_IDLE;
				end
				default: begin
					rl_state_q <= RL_IDLE;
				end
			endcase

			if (exec_we) begin
				pc_q <= ex.pc;
			end

			// Multiply: first cycle fills the partial products
			if (s1_fire) begin
				mul_done_q <= 1'b0;
			end else if (s1_valid_q && ex.is_mul) begin
				mul_done_q <= 1'b1;
			end

			if (in_fire) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end

			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			instr_s1 <= instr.payload;
			a_byp_s1 <= ram_we && (ram_waddr == in_a_idx);
			b_byp_s1 <= ram_we && (ram_waddr == in_b_idx);
			a_vld_s1 <= valid_q[in_a_idx];
			b_vld_s1 <= valid_q[in_b_idx];
			byp_s1 <= ram_wdata;
		end
		if (s1_fire) begin
			out_q.written_value <= ex.value;
			out_q.dest_reg <= ex.fault ? 3'd0 : s1.dest_index[2:0];
			out_q.next_pc <= ex.pc;
			out_q.halted <= ex.halted;
			out_q.fault <= ex.fault;
		end
	end

	assign result.valid = out_valid_q;
	assign result.payload = out_q;

	a_reload_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(rl_state_q != RL_IDLE) |-> (!instr.ready && !cfg.ready))
		else $error("item or config taken during pc reload");

	a_mul_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && ex.is_mul) |-> mul_done_q)
		else $error("multiply retired before partial products were ready");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.fault) |-> ((out_q.written_value == '0)
		&& (out_q.dest_reg == 3'd0)))
		else $error("faulted item reports a write");

	a_neg_pc_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.next_pc[DATA_W-1]) |-> out_q.halted)
		else $error("negative pc without halt");

	a_no_write_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && ex.fault) |=> $stable(pc_q))
		else $error("faulted item moved the pc");
endmodule

>>> design/rme_ram.sv
module rme_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 6
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re_a,
	input logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input logic re_b,
	input logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0] rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem_q[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem_q[raddr_b];
		end
	end
endmodule

>>> design/rme_mul.sv
module rme_mul import rme_pkg::*; (
	input logic clk,
	input logic [DATA_W-1:0] x,
	input logic [DATA_W-1:0] y,
	output logic [DATA_W-1:0] prod
);
	// Low 64 bits of x*y from three 32x32 partial products
	logic [DATA_W-1:0] lo_q;
	logic [31:0] cross_a_q;
	logic [31:0] cross_b_q;
	logic [DATA_W-1:0] lo_d;
	logic [31:0] cross_a_d;
	logic [31:0] cross_b_d;
	logic [31:0] cross_sum;

	assign lo_d = x[31:0] * y[31:0];
	assign cross_a_d = x[31:0] * y[63:32];
	assign cross_b_d = x[63:32] * y[31:0];

	always_ff @(posedge clk) begin
		lo_q <= lo_d;
		cross_a_q <= cross_a_d;
		cross_b_q <= cross_b_d;
	end

	assign cross_sum = cross_a_q + cross_b_q;
	assign prod = lo_q + {cross_sum, 32'd0};
endmodule

>>> design/rme_alu.sv
module rme_alu import rme_pkg::*; #(
	parameter int NUM_REGS = NUM_REGS_DEF
) (
	input logic [3:0] opcode,
	input logic [OPND_W-1:0] operand_a,
	input logic [OPND_W-1:0] operand_b,
	input logic [OPND_W-1:0] dest_index,
	input logic [IP_W-1:0] ip_reg,
	input logic [PLEN_W-1:0] prog_len,
	input logic [DATA_W-1:0] pc,
	input logic [DATA_W-1:0] ra,
	input logic [DATA_W-1:0] rb,
	input logic [DATA_W-1:0] mul_prod,
	output logic [DATA_W-1:0] va,
	output logic [DATA_W-1:0] vb,
	output exec_t ex
);
	localparam logic [OPND_W-1:0] NREGS = OPND_W'(NUM_REGS);
	localparam logic [31:0] MAXP = 32'(MAX_PROGRAM);

	op_t op;
	logic a_reg;
	logic b_reg;
	logic ip_ok;
	logic fault;
	logic dest_is_ip;
	logic [DATA_W-1:0] res;
	logic [DATA_W-1:0] base;
	logic [DATA_W-1:0] next_pc;
	logic [31:0] plen;

	assign op = op_t'(opcode);

	always_comb begin
		a_reg = 1'b0;
		b_reg = 1'b0;
		case (op)
			OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTRR, OP_EQRR: begin
				a_reg = 1'b1;
				b_reg = 1'b1;
			end
			OP_ADDI, OP_MULI, OP_BANI, OP_BORI, OP_SETR, OP_GTRI, OP_EQRI: begin
				a_reg = 1'b1;
			end
			OP_GTIR, OP_EQIR: begin
				b_reg = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign ip_ok = OPND_W'(ip_reg) < NREGS;
	assign fault = !ip_ok || (dest_index >= NREGS)
		|| (a_reg && (operand_a >= NREGS)) || (b_reg && (operand_b >= NREGS));

	assign va = a_reg ? ra : DATA_W'(operand_a);
	assign vb = b_reg ? rb : DATA_W'(operand_b);

	always_comb begin
		case (op)
			OP_ADDR, OP_ADDI: res = va + vb;
			OP_MULR, OP_MULI: res = mul_prod;
			OP_BANR, OP_BANI: res = va & vb;
			OP_BORR, OP_BORI: res = va | vb;
			OP_SETR, OP_SETI: res = va;
			OP_GTIR, OP_GTRI, OP_GTRR: res = {63'd0, $signed(va) > $signed(vb)};
			default: res = {63'd0, va == vb};
		endcase
	end

	// A write to the bound register is what gets incremented
	assign dest_is_ip = dest_index == OPND_W'(ip_reg);
	assign base = dest_is_ip ? res : pc;

	always_comb begin
		if (fault) begin
			next_pc = ip_ok ? pc : '0;
		end else begin
			next_pc = base + DATA_W'(1);
		end
	end

	assign plen = (32'(prog_len) > MAXP) ? MAXP : 32'(prog_len);

	assign ex.value = fault ? '0 : res;
	assign ex.pc = next_pc;
	assign ex.halted = next_pc[DATA_W-1] || (next_pc >= DATA_W'(plen));
	assign ex.fault = fault;
	assign ex.is_mul = (op == OP_MULR) || (op == OP_MULI);
endmodule

>>> tb/sv/register_machine_execute_test.sv
module register_machine_execute_test;
	import rme_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// No register lives at this index; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(15);

	typedef enum logic {ROW_INSTR, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		instr_t ins;
		cfg_t cw;
		bit known;
		result_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	rme_chan_if #(.payload_t(instr_t)) instr_ch ();
	rme_chan_if #(.payload_t(result_t)) result_ch ();
	rme_chan_if #(.payload_t(cfg_t)) cfg_ch ();

	register_machine_execute dut (
		.clk(clk),
		.arst_n(arst_n),
		.instr(instr_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	// Machine state as the block should hold it
	logic [DATA_W-1:0] mach_regs [NUM_REGS_DEF];
	logic [IP_W-1:0] ip_sel;
	logic [PLEN_W-1:0] prog_len;

	result_t due_results [$];
	dir_row_t script [$];
	int mismatches;
	int send_idle;
	int recv_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic void operand_kinds(input op_t op, output logic a_reg,
			output logic b_reg);
		case (op)
			OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTRR, OP_EQRR: begin
				a_reg = 1'b1;
				b_reg = 1'b1;
			end
			OP_ADDI, OP_MULI, OP_BANI, OP_BORI, OP_SETR, OP_GTRI, OP_EQRI: begin
				a_reg = 1'b1;
				b_reg = 1'b0;
			end
			OP_GTIR, OP_EQIR: begin
				a_reg = 1'b0;
				b_reg = 1'b1;
			end
			default: begin
				a_reg = 1'b0;
				b_reg = 1'b0;
			end
		endcase
	endfunction

	// Execute one instruction against the modeled state and return its result
	function automatic result_t execute_instr(instr_t ins);
		logic a_reg, b_reg, bad;
		logic [DATA_W-1:0] va, vb, res, pc;
		logic [PLEN_W-1:0] lim;
		result_t r;
		op_t op;
		op = op_t'(ins.opcode);
		operand_kinds(op, a_reg, b_reg);
		lim = (prog_len > MAX_PROGRAM) ? PLEN_W'(MAX_PROGRAM) : prog_len;
		bad = (ip_sel >= NUM_REGS_DEF) || (ins.dest_index >= NUM_REGS_DEF)
			|| (a_reg && ins.operand_a >= NUM_REGS_DEF)
			|| (b_reg && ins.operand_b >= NUM_REGS_DEF);
		va = DATA_W'(ins.operand_a);
		vb = DATA_W'(ins.operand_b);
		res = '0;
		if (bad) begin
			pc = (ip_sel >= NUM_REGS_DEF) ? '0 : mach_regs[ip_sel];
			r.written_value = '0;
			r.dest_reg = '0;
		end else begin
			if (a_reg) va = mach_regs[ins.operand_a];
			if (b_reg) vb = mach_regs[ins.operand_b];
			case (op)
				OP_ADDR, OP_ADDI: res = va + vb;
				OP_MULR, OP_MULI: res = va * vb;
				OP_BANR, OP_BANI: res = va & vb;
				OP_BORR, OP_BORI: res = va | vb;
				OP_SETR, OP_SETI: res = va;
				OP_GTIR, OP_GTRI, OP_GTRR: res = ($signed(va) > $signed(vb)) ? 64'd1 : 64'd0;
				default: res = (va == vb) ? 64'd1 : 64'd0;
			endcase
			mach_regs[ins.dest_index] = res;
			// the bound register advances after the write, even onto itself
			mach_regs[ip_sel] = mach_regs[ip_sel] + 64'd1;
			pc = mach_regs[ip_sel];
			r.written_value = res;
			r.dest_reg = ins.dest_index[2:0];
		end
		r.next_pc = pc;
		r.halted = pc[DATA_W-1] || (pc >= DATA_W'(lim));
		r.fault = bad;
		return r;
	endfunction

	function automatic void add_instr(op_t op, logic [31:0] a, logic [31:0] b,
			logic [31:0] d);
		dir_row_t row;
		row.kind = ROW_INSTR;
		row.ins = {op, a, b, d};
		row.cw = '0;
		row.known = 1'b0;
		row.want = '0;
		script = {script, row};
	endfunction

	function automatic void add_known(op_t op, logic [31:0] a, logic [31:0] b,
			logic [31:0] d, logic [63:0] wv, logic [2:0] dr, logic [63:0] pc,
			logic halt, logic flt);
		dir_row_t row;
		row.kind = ROW_INSTR;
		row.ins = {op, a, b, d};
		row.cw = '0;
		row.known = 1'b1;
		row.want.written_value = wv;
		row.want.dest_reg = dr;
		row.want.next_pc = pc;
		row.want.halted = halt;
		row.want.fault = flt;
		script = {script, row};
	endfunction

	function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		dir_row_t row;
		row.kind = ROW_CFG;
		row.ins = '0;
		row.cw.reg_index = idx;
		row.cw.wdata = data;
		row.known = 1'b0;
		row.want = '0;
		script = {script, row};
	endfunction

	function automatic logic [31:0] rand_reg();
		if ($urandom_range(0, 15) != 0) return $urandom_range(0, NUM_REGS_DEF - 1);
		case ($urandom_range(0, 2))
			0: return 32'd6;
			1: return 32'd7;
			default: return $urandom | 32'd8;
		endcase
	endfunction

	function automatic logic [31:0] rand_imm();
		case ($urandom_range(0, 5))
			0, 1: return $urandom_range(0, 15);
			2: return 32'hFFFF_FFFF;
			3: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic instr_t rand_instr();
		instr_t ins;
		logic a_reg, b_reg;
		ins.opcode = 4'($urandom_range(0, 15));
		operand_kinds(op_t'(ins.opcode), a_reg, b_reg);
		ins.operand_a = a_reg ? rand_reg() : rand_imm();
		ins.operand_b = b_reg ? rand_reg() : rand_imm();
		ins.dest_index = rand_reg();
		// jump now and then so the pc comes back inside the program
		if ($urandom_range(0, 7) == 0 && ip_sel < NUM_REGS_DEF) begin
			ins.opcode = OP_SETI;
			ins.operand_a = $urandom_range(0, 300);
			ins.dest_index = 32'(ip_sel);
		end
		return ins;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (mismatches < 40)
			$display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	// Called just after a falling edge; returns just after a falling edge
	task automatic send_instr(instr_t ins, bit known, result_t want);
		result_t r;
		while ($urandom_range(0, 99) < send_idle) begin
			instr_ch.valid = 1'b0;
			@(negedge clk);
		end
		instr_ch.valid = 1'b1;
		instr_ch.payload = ins;
		do @(posedge clk); while (instr_ch.ready !== 1'b1);
		r = execute_instr(ins);
		if (known)
			r = want;
		due_results = {due_results, r};
		@(negedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_t cw;
		cw.reg_index = idx;
		cw.wdata = data;
		instr_ch.valid = 1'b0;
		// drain the pipe before touching configuration
		while (due_results.size() != 0) @(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.payload = cw;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		if (idx == CFG_IP_REGISTER)
			ip_sel = data[IP_W-1:0];
		else if (idx == CFG_PROGRAM_LENGTH)
			prog_len = data;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	always @(negedge clk) begin
		result_ch.ready = ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin : check_results
		result_t got, want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			got = result_ch.payload;
			if (due_results.size() == 0) begin
				report_mismatch("unexpected item", got.written_value, '0);
			end else begin
				want = due_results.pop_front();
				if (got.written_value !== want.written_value)
					report_mismatch("written_value", got.written_value, want.written_value);
				if (got.dest_reg !== want.dest_reg)
					report_mismatch("dest_reg", 64'(got.dest_reg), 64'(want.dest_reg));
				if (got.next_pc !== want.next_pc)
					report_mismatch("next_pc", got.next_pc, want.next_pc);
				if (got.halted !== want.halted)
					report_mismatch("halted", 64'(got.halted), 64'(want.halted));
				if (got.fault !== want.fault)
					report_mismatch("fault", 64'(got.fault), 64'(want.fault));
			end
		end
	end

	initial begin
		int send_pct [3];
		int recv_pct [3];
		logic [IP_W-1:0] ip_pick;
		logic [CFG_DATA_W-1:0] len_pick;
		send_pct = '{11, 67, 0};
		recv_pct = '{67, 11, 0};
		arst_n = 1'b0;
		instr_ch.valid = 1'b0;
		instr_ch.payload = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		result_ch.ready = 1'b0;
		mismatches = 0;
		send_idle = send_pct[0];
		recv_idle = recv_pct[0];
		foreach (mach_regs[i]) mach_regs[i] = '0;
		ip_sel = '0;
		prog_len = '0;

		// Out of reset: pc in register 0, empty program, so everything halts
		add_known(OP_SETI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd3,
			64'h0000_0000_FFFF_FFFF, 3'd3, 64'd1, 1'b1, 1'b0);
		add_known(OP_ADDR, 32'd3, 32'd3, 32'd3,
			64'h0000_0001_FFFF_FFFE, 3'd3, 64'd2, 1'b1, 1'b0);
		add_known(OP_ADDR, 32'd6, 32'd0, 32'd1, 64'd0, 3'd0, 64'd2, 1'b1, 1'b1);
		add_known(OP_ADDI, 32'd0, 32'd5, 32'hFFFF_FFFF, 64'd0, 3'd0, 64'd2, 1'b1, 1'b1);
		add_known(OP_GTIR, 32'hFFFF_FFFF, 32'd7, 32'd0, 64'd0, 3'd0, 64'd2, 1'b1, 1'b1);
		// write straight into the pc register
		add_known(OP_SETI, 32'hFFFF_FFFF, 32'd0, 32'd0,
			64'h0000_0000_FFFF_FFFF, 3'd0, 64'h0000_0001_0000_0000, 1'b1, 1'b0);
		add_instr(OP_MULI, 32'd3, 32'hFFFF_FFFF, 32'd4);
		add_instr(OP_GTIR, 32'd0, 32'd4, 32'd2);
		add_instr(OP_GTRI, 32'd4, 32'd0, 32'd2);
		add_instr(OP_GTRR, 32'd3, 32'd4, 32'd5);
		add_instr(OP_SETR, 32'd4, 32'd0, 32'd0);
		add_instr(OP_MULR, 32'd4, 32'd4, 32'd4);
		add_instr(OP_BANR, 32'd3, 32'd4, 32'd5);
		add_instr(OP_BANI, 32'd4, 32'hAAAA_AAAA, 32'd5);
		add_instr(OP_BORR, 32'd3, 32'd4, 32'd2);
		add_instr(OP_BORI, 32'd2, 32'h5555_5555, 32'd1);
		add_instr(OP_SETR, 32'd4, 32'hFFFF_FFFF, 32'd1);
		add_instr(OP_EQIR, 32'd1, 32'd2, 32'd5);
		add_instr(OP_EQRI, 32'd1, 32'hFFFF_FFFF, 32'd3);
		add_instr(OP_EQRR, 32'd2, 32'd2, 32'd2);
		// pc in register 5; oversized length clamps to the maximum program
		add_cfg(CFG_IP_REGISTER, 9'h1FD);
		add_cfg(CFG_PROGRAM_LENGTH, 9'h1FF);
		add_known(OP_SETI, 32'd250, 32'd0, 32'd5, 64'd250, 3'd5, 64'd251, 1'b0, 1'b0);
		add_known(OP_SETI, 32'd255, 32'd0, 32'd5, 64'd255, 3'd5, 64'd256, 1'b1, 1'b0);
		add_cfg(CFG_PROGRAM_LENGTH, 9'd256);
		add_known(OP_SETI, 32'd254, 32'd0, 32'd5, 64'd254, 3'd5, 64'd255, 1'b0, 1'b0);
		// pc bound to a register that does not exist
		add_cfg(CFG_IP_REGISTER, 9'd7);
		add_known(OP_ADDI, 32'd0, 32'd1, 32'd0, 64'd0, 3'd0, 64'd0, 1'b0, 1'b1);
		add_cfg(CFG_PROGRAM_LENGTH, 9'd0);
		add_cfg(CFG_SPARE, 9'h1FF);
		add_known(OP_SETI, 32'd1, 32'd0, 32'd0, 64'd0, 3'd0, 64'd0, 1'b1, 1'b1);
		add_cfg(CFG_IP_REGISTER, 9'h0FE);
		add_known(OP_SETI, 32'd3, 32'd0, 32'd2, 64'd0, 3'd0, 64'd0, 1'b1, 1'b1);

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG)
				write_cfg(script[i].cw.reg_index, script[i].cw.wdata);
			else
				send_instr(script[i].ins, script[i].known, script[i].want);
		end

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = send_pct[ph];
			recv_idle = recv_pct[ph];
			for (int blk = 0; blk < 5; blk++) begin
				if ($urandom_range(0, 11) == 0)
					ip_pick = IP_W'(6 + $urandom_range(0, 1));
				else
					ip_pick = IP_W'($urandom_range(0, NUM_REGS_DEF - 1));
				case ($urandom_range(0, 5))
					0: len_pick = 9'd0;
					1: len_pick = 9'd256;
					2: len_pick = 9'h1FF;
					3: len_pick = 9'($urandom_range(1, 16));
					default: len_pick = 9'($urandom_range(0, 300));
				endcase
				write_cfg(CFG_IP_REGISTER, {6'($urandom_range(0, 63)), ip_pick});
				write_cfg(CFG_PROGRAM_LENGTH, len_pick);
				repeat (27) send_instr(rand_instr(), 1'b0, '0);
			end
		end

		instr_ch.valid = 1'b0;
		while (due_results.size() != 0) @(negedge clk);
		// catch any stray item after the last one
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
